// ===== src/vbt_pkg.sv =====
// ---------------------------------------------------------------------------
// vbt_pkg
// Shared types and codes of the variable binding table.
// ---------------------------------------------------------------------------
package vbt_pkg;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_GET   = 2'd2;
  localparam logic [1:0] REQ_DIRTY = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        binding_kind;
    logic [15:0] var_id;
    logic [31:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    logic        is_dirty;
    logic        status;
  } out_word_t;

  typedef struct packed {
    logic [15:0] id;
    logic        kind;
    logic        dirty;
    logic [31:0] value;
  } entry_t;

endpackage

// ===== src/variable_binding_table_core.sv =====
// ---------------------------------------------------------------------------
// variable_binding_table_core
// Table of variable bindings with init, set, get and dirty-query requests.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the word is taken at the
//   edge where start is high and busy is low. busy stays high until the
//   request has fully finished, including any write-back.
//   Result channel: done pulses for one cycle with rsp valid; the receiver
//   cannot stall, so it must take the word in that cycle.
//   APB port: one register, undefined_value, at byte address 0; writes take
//   setup and access cycles, pready is tied high. Write only when idle.
// Sequence:
//   The store is scanned one entry a cycle through its read port (SCAN,
//   then LAST), then DECIDE answers; an empty table goes straight to
//   DECIDE. A write that also updates the other-kind entry adds a WR2
//   state. A new request is taken only once the block is back in idle.
// Reset:
//   rst (synchronous) empties the table and clears undefined_value; no
//   clearing pass is needed since only appended entries are ever read.
// ---------------------------------------------------------------------------
module variable_binding_table_core #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vbt_pkg::in_word_t  req,
  output logic               done,
  output vbt_pkg::out_word_t rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import vbt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [31:0]   undefined_value;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  // APB register bank: one word, decoded on the word address bit
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? undefined_value : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      undefined_value <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      undefined_value <= pwdata;
    end
  end

  vbt_ctrl #(
    .ENTRIES(ENTRIES),
    .AW     (AW),
    .CW     (CW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req            (req),
    .undefined_value(undefined_value),
    .done           (done),
    .rsp            (rsp),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data)
  );

  // entry store: id, kind, dirty mark and value per row
  vbt_mem #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

// ===== src/vbt_mem.sv =====
// ---------------------------------------------------------------------------
// vbt_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module vbt_mem #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  vbt_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output vbt_pkg::entry_t rd_data
);
  import vbt_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/vbt_ctrl.sv =====
// ---------------------------------------------------------------------------
// vbt_ctrl
// Request sequencer: scans the store, decides, writes back, emits the word.
// ---------------------------------------------------------------------------
module vbt_ctrl #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4,
  parameter int CW      = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vbt_pkg::in_word_t  req,
  input  logic [31:0]        undefined_value,
  output logic               done,
  output vbt_pkg::out_word_t rsp,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output vbt_pkg::entry_t    wr_data,
  output logic [AW-1:0]      rd_addr,
  input  vbt_pkg::entry_t    rd_data
);
  import vbt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WR2    = 3'd4;

  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  logic [2:0]    state;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic          pend;
  logic [AW-1:0] pend_idx;
  in_word_t      cur;

  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic [31:0]   hit_value;
  logic          oth_found;
  logic [AW-1:0] oth_idx;
  logic [31:0]   oth_value;
  logic          any_found;
  logic          any_dirty;

  logic      accept;
  logic      is_write;
  logic      mark;
  logic      full_refuse;
  out_word_t rsp_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign rd_addr  = idx[AW-1:0];
  assign is_write = (cur.req_type == REQ_INIT) || (cur.req_type == REQ_SET);
  assign mark     = (cur.req_type == REQ_SET);
  assign full_refuse = is_write && !hit_found && (count == FULL);

  // result of the request being decided
  always_comb begin
    rsp_next = '0;
    unique case (cur.req_type)
      REQ_INIT, REQ_SET: begin
        rsp_next.found  = hit_found;
        rsp_next.status = full_refuse;
      end
      REQ_GET: begin
        rsp_next.found      = hit_found;
        rsp_next.read_value = hit_found ? hit_value : undefined_value;
      end
      REQ_DIRTY: begin
        rsp_next.found    = any_found;
        rsp_next.is_dirty = any_found && any_dirty;
      end
      default: rsp_next = '0;
    endcase
  end

  // write-back port: own entry in DECIDE, other-kind entry in WR2
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_found ? hit_idx : count[AW-1:0];
    wr_data = '{id: cur.var_id, kind: cur.binding_kind, dirty: mark,
                value: cur.write_value};
    if (state == S_DECIDE) begin
      wr_en = is_write && !full_refuse;
    end else if (state == S_WR2) begin
      wr_en   = 1'b1;
      wr_addr = oth_idx;
      wr_data = '{id: cur.var_id, kind: ~cur.binding_kind, dirty: mark,
                  value: mark ? cur.write_value : oth_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx   <= '0;
            state <= (count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= 1'b1;
          pend_idx <= idx[AW-1:0];
          idx      <= idx + 1'b1;
          if (idx + 1'b1 == count) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          done <= 1'b1;
          if (is_write && !hit_found && !full_refuse) begin
            count <= count + 1'b1;
          end
          state <= (is_write && !full_refuse && oth_found) ? S_WR2 : S_IDLE;
        end
        S_WR2: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture, match tracking and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cur       <= req;
      hit_found <= 1'b0;
      oth_found <= 1'b0;
      any_found <= 1'b0;
      any_dirty <= 1'b0;
    end else if (pend && rd_data.id == cur.var_id) begin
      if (!any_found) begin
        any_found <= 1'b1;
        any_dirty <= rd_data.dirty;
      end
      if (rd_data.kind == cur.binding_kind) begin
        if (!hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= pend_idx;
          hit_value <= rd_data.value;
        end
      end else if (!oth_found) begin
        oth_found <= 1'b1;
        oth_idx   <= pend_idx;
        oth_value <= rd_data.value;
      end
    end
    if (state == S_DECIDE) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== src/vbt_check.sv =====
// ---------------------------------------------------------------------------
// vbt_check
// Port-level checks on the binding table, bound to the top level.
// ---------------------------------------------------------------------------
module vbt_check (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input vbt_pkg::out_word_t rsp
);
  import vbt_pkg::*;

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a result word only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without request in flight");

  // a refused insert never reports a match
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status) |-> (!rsp.found && !rsp.is_dirty))
    else $error("full status with found or dirty");

  // a dirty mark is only reported for an existing entry
  a_dirty_found: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.is_dirty) |-> rsp.found)
    else $error("dirty without found");

endmodule

bind variable_binding_table_core vbt_check u_check (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .rsp  (rsp)
);
